@@ rtl/wsclock_page_replacement_defines.svh @@
// Assertion helpers used by the page replacement RTL.
`ifndef WSCLOCK_PAGE_REPLACEMENT_DEFINES_SVH
`define WSCLOCK_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wsc_pkg.sv @@
package wsc_pkg;

    // Default sizes
    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    // Fixed port field widths
    localparam int PAGE_IN_W  = 16;
    localparam int THR_W      = 16;
    localparam int TIME_W     = 32;
    localparam int OUT_IDX_W  = 3;
    localparam int OUT_PAGE_W = 16;
    localparam int M_DATA_W   = 24;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

    // Microprogram step addresses
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_PROBE,
        S_TOUCH,
        S_EMIT
    } step_t;

    // Datapath operation of a step
    typedef enum logic [2:0] {
        OP_WAIT,
        OP_LOOK,
        OP_PROBE,
        OP_TOUCH,
        OP_EMIT
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_IN_XFER,
        C_PLACED,
        C_SCAN_END,
        C_VICTIM,
        C_OUT_FREE
    } cond_t;

    // One control word
    typedef struct packed {
        op_t   op;
        logic  hand_addr;   // memory read for the next step uses the clock hand
        cond_t cond_a;
        step_t tgt_a;
        cond_t cond_b;
        step_t tgt_b;
    } ucode_t;

    // Control store; a step with neither condition true repeats itself
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t cw;
        unique case (step)
            S_IDLE:  cw = '{OP_WAIT,  1'b0, C_IN_XFER,  S_LOOK,  C_NEVER,    S_IDLE};
            S_LOOK:  cw = '{OP_LOOK,  1'b0, C_PLACED,   S_TOUCH, C_SCAN_END, S_PROBE};
            S_PROBE: cw = '{OP_PROBE, 1'b1, C_VICTIM,   S_TOUCH, C_NEVER,    S_IDLE};
            S_TOUCH: cw = '{OP_TOUCH, 1'b0, C_ALWAYS,   S_EMIT,  C_NEVER,    S_IDLE};
            S_EMIT:  cw = '{OP_EMIT,  1'b0, C_OUT_FREE, S_IDLE,  C_NEVER,    S_IDLE};
            default: cw = '{OP_EMIT,  1'b0, C_ALWAYS,   S_IDLE,  C_NEVER,    S_IDLE};
        endcase
        return cw;
    endfunction

endpackage

@@ rtl/wsclock_page_replacement.sv @@
// On accept the frames are scanned for the page; a hit or a miss with a free frame goes
// to the touch and emit steps, and a miss with all frames in use first sweeps the hand
// to a victim. The scan and the sweep step one frame per cycle through the page and
// time memories. A new reference is taken only once the last result is registered.
// Reset (aresetn low, synchronous): frames empty, referenced bits, hand and time zero,
// age threshold 5; page and time memories keep their contents and need no clearing.
`include "wsclock_page_replacement_defines.svh"

module wsclock_page_replacement
    import wsc_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // config: age_threshold
    input  logic                cfg_wr_en,
    input  logic [THR_W-1:0]    cfg_wr_data,
    // input: [15:0] page_number
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [PAGE_IN_W-1:0] s_tdata,
    // output: [0] was_hit, [3:1] frame_index, [4] did_evict, [20:5] evicted_page
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int IDXW = $clog2(FRAMES);
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(FRAMES - 1);

    // Sequencer and datapath registers
    step_t                 upc_reg, upc_next;
    logic [IDXW-1:0]       idx_reg, idx_next;
    logic [IDXW-1:0]       hand_reg, hand_next;
    logic [IDXW-1:0]       slot_reg, slot_next;
    logic [TIME_W-1:0]     vtime_reg, vtime_next;
    logic [THR_W-1:0]      thr_reg, thr_next;
    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic [PAGE_BITS-1:0]  victim_reg, victim_next;
    logic                  hit_reg, hit_next;
    logic                  evict_reg, evict_next;
    logic                  free_found_reg, free_found_next;
    logic [FRAMES-1:0]     valid_reg, valid_next;
    logic [FRAMES-1:0]     ref_reg, ref_next;

    // Result register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // Memory ports
    logic [IDXW-1:0]       rd_addr;
    logic [PAGE_BITS-1:0]  rd_page;
    logic [TIME_W-1:0]     rd_time;
    logic                  page_we;
    logic                  time_we;

    ucode_t                cw;
    ucode_t                cw_next;

    logic [PAGE_BITS-1:0]  page_in;
    logic                  cur_valid;
    logic                  match;
    logic                  scan_end;
    logic                  placed;
    logic                  hand_ref;
    logic [TIME_W-1:0]     vtime_inc;
    logic [TIME_W-1:0]     age;
    logic                  young;
    logic                  victim_now;
    logic                  out_free;
    logic [IDXW-1:0]       hand_inc;

    assign cw = ucode_rom(upc_reg);

    // Page number reduced to the stored width
    assign page_in = PAGE_BITS'(s_tdata);

    // Scan and probe conditions
    assign cur_valid  = valid_reg[idx_reg];
    assign match      = cur_valid && (rd_page == page_reg);
    assign scan_end   = (idx_reg == IDX_LAST);
    assign placed     = match || (scan_end && (free_found_reg || !cur_valid));
    assign hand_ref   = ref_reg[hand_reg];
    assign vtime_inc  = vtime_reg + TIME_W'(1);
    assign age        = vtime_inc - rd_time;
    assign young      = (age < TIME_W'(thr_reg));
    assign victim_now = !hand_ref && !young;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign hand_inc   = (hand_reg == IDX_LAST) ? '0 : hand_reg + IDXW'(1);

    function automatic logic cond_true(input cond_t c, input logic in_xfer,
                                       input logic plc, input logic send,
                                       input logic vict, input logic ofree);
        logic r;
        case (c)
            C_NEVER:    r = 1'b0;
            C_ALWAYS:   r = 1'b1;
            C_IN_XFER:  r = in_xfer;
            C_PLACED:   r = plc;
            C_SCAN_END: r = send;
            C_VICTIM:   r = vict;
            C_OUT_FREE: r = ofree;
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    // Next step
    always_comb begin
        if (cond_true(cw.cond_a, s_tvalid, placed, scan_end, victim_now, out_free)) begin
            upc_next = cw.tgt_a;
        end else if (cond_true(cw.cond_b, s_tvalid, placed, scan_end, victim_now,
                               out_free)) begin
            upc_next = cw.tgt_b;
        end else begin
            upc_next = upc_reg;
        end
    end

    // Datapath per control word
    always_comb begin
        idx_next        = idx_reg;
        hand_next       = hand_reg;
        slot_next       = slot_reg;
        vtime_next      = vtime_reg;
        page_next       = page_reg;
        victim_next     = victim_reg;
        hit_next        = hit_reg;
        evict_next      = evict_reg;
        free_found_next = free_found_reg;
        valid_next      = valid_reg;
        ref_next        = ref_reg;
        thr_next        = cfg_wr_en ? cfg_wr_data : thr_reg;

        unique case (cw.op)
            OP_WAIT: begin
                if (s_tvalid) begin
                    page_next       = page_in;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    hit_next        = 1'b0;
                    evict_next      = 1'b0;
                    victim_next     = '0;
                end
            end
            OP_LOOK: begin
                if (match) begin
                    hit_next  = 1'b1;
                    slot_next = idx_reg;
                end else if (!cur_valid && !free_found_reg) begin
                    free_found_next = 1'b1;
                    slot_next       = idx_reg;
                end
                if (!placed && !scan_end) begin
                    idx_next = idx_reg + IDXW'(1);
                end
                // a fault costs one tick before the fill or the sweep
                if (scan_end && !match) begin
                    vtime_next = vtime_inc;
                end
            end
            OP_PROBE: begin
                vtime_next = vtime_inc;
                if (hand_ref) begin
                    ref_next[hand_reg] = 1'b0;
                    hand_next          = hand_inc;
                end else if (young) begin
                    hand_next = hand_inc;
                end else begin
                    slot_next   = hand_reg;
                    evict_next  = 1'b1;
                    victim_next = rd_page;
                end
            end
            OP_TOUCH: begin
                vtime_next           = vtime_inc;
                ref_next[slot_reg]   = 1'b1;
                valid_next[slot_reg] = 1'b1;
            end
            OP_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // Handshake, memory control and result register
    always_comb begin
        cw_next       = ucode_rom(upc_next);
        s_tready      = (cw.op == OP_WAIT);
        page_we       = (cw.op == OP_TOUCH) && !hit_reg;
        time_we       = (cw.op == OP_TOUCH);
        rd_addr       = cw_next.hand_addr ? hand_next : idx_next;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if ((cw.op == OP_EMIT) && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(M_DATA_W - 5 - OUT_PAGE_W){1'b0}},
                             OUT_PAGE_W'(victim_reg), evict_reg,
                             OUT_IDX_W'(slot_reg), hit_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Frame page numbers
    wsc_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAMES)
    ) u_page_ram (
        .aclk  (aclk),
        .we    (page_we),
        .waddr (slot_reg),
        .wdata (page_reg),
        .raddr (rd_addr),
        .rdata (rd_page)
    );

    // Frame last-use times
    wsc_ram #(
        .WIDTH (TIME_W),
        .DEPTH (FRAMES)
    ) u_time_ram (
        .aclk  (aclk),
        .we    (time_we),
        .waddr (slot_reg),
        .wdata (vtime_inc),
        .raddr (rd_addr),
        .rdata (rd_time)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg      <= S_IDLE;
            hand_reg     <= '0;
            vtime_reg    <= '0;
            thr_reg      <= THR_RESET;
            valid_reg    <= '0;
            ref_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            upc_reg      <= upc_next;
            hand_reg     <= hand_next;
            vtime_reg    <= vtime_next;
            thr_reg      <= thr_next;
            valid_reg    <= valid_next;
            ref_reg      <= ref_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        slot_reg       <= slot_next;
        page_reg       <= page_next;
        victim_reg     <= victim_next;
        hit_reg        <= hit_next;
        evict_reg      <= evict_next;
        free_found_reg <= free_found_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // Checks
    `WSC_ASSERT_IMPL(a_probe_full, aclk, aresetn, upc_reg == S_PROBE, &valid_reg, "sweep with a free frame")
    `WSC_ASSERT_NEXT(a_touch_marks, aclk, aresetn, upc_reg == S_TOUCH, valid_reg[$past(slot_reg)] && ref_reg[$past(slot_reg)], "touched frame not marked")
    `WSC_ASSERT_NEXT(a_time_quiet, aclk, aresetn, upc_reg == S_IDLE || upc_reg == S_EMIT, vtime_reg == $past(vtime_reg), "time moved outside a reference")
    `WSC_ASSERT_IMPL(a_hit_no_evict, aclk, aresetn, m_tvalid_reg, !(m_tdata_reg[0] && m_tdata_reg[4]), "eviction reported on a hit")

endmodule

@@ rtl/wsc_ram.sv @@
module wsc_ram
    import wsc_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port (read-first)
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
